### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/tlc_pkg.sv
package tlc_pkg;

    // Table geometry
    localparam int MAX_CLUSTERS = 16;
    localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

    // Configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    localparam logic [11:0] THRESHOLD_RST = 12'd20;
    localparam logic [4:0]  ACTIVE_RST    = 5'd16;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // One table entry as stored in RAM
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cnt;
        logic [15:0] sx;
        logic [15:0] sy;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_CMP,
        ST_DIV,
        ST_WB,
        ST_DONE
    } t_state;

endpackage

### design/tlc_ram.sv
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/threshold_leader_clustering_unit.sv
// Threshold leader clustering unit.
// Input: pulse start with i_point_x/i_point_y (unsigned Q12.4) while busy is
// low; the point is taken at that edge and busy rises on the next cycle.
// Output: o_done is high for exactly one cycle with o_cluster_index, o_found
// and o_seeded; the receiver cannot stall, so the result is simply shown once.
// Config: i_cfg_we with i_cfg_idx (0 threshold, 1 active_clusters) and
// i_cfg_data, written at once; write only while busy is low.
// Scan: one slot visit per slot below active_clusters (clipped to the table
// depth). An empty slot is passed over in the read state; a valid slot goes
// through read, difference, square and compare, and a matching one then runs
// two 16-step restoring dividers side by side for the running mean and a
// write-back. The table lives in one single-port RAM with registered read, so
// slots are handled one at a time.
// Reset clears the slot valid bits and the control registers; no clearing
// pass is needed since a slot's count and spread are zeroed when it is seeded.
module threshold_leader_clustering_unit
    import tlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output logic        o_done,
    output logic [3:0]  o_cluster_index,
    output logic        o_found,
    output logic        o_seeded
);

`include "assert_macros.svh"

    t_state r_state, n_state;

    logic [11:0] r_thr;
    logic [4:0]  r_active;
    logic [MAX_CLUSTERS-1:0] r_valid;

    logic [15:0] r_px, r_py;
    logic [31:0] r_lim2;
    logic [CNT_W-1:0] r_i;
    logic [IDX_W-1:0] r_idx, r_free;
    logic r_hit, r_free_ok;

    t_rec r_rec;
    logic [15:0] r_dx, r_dy;
    logic [31:0] r_dx2, r_dy2;
    logic [16:0] r_rx, r_ry, r_d;
    logic [15:0] r_qx, r_qy;
    logic [3:0]  r_step;

    logic r_done, r_found, r_seeded;
    logic [3:0] r_oidx;

    // RAM port
    logic ram_we;
    logic [IDX_W-1:0] ram_addr;
    t_rec ram_wdata, ram_rdata;

    tlc_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_CLUSTERS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Loop bound: active count clipped to table depth
    logic [7:0] act8, n8, i8;
    logic       scan_end;
    logic [IDX_W-1:0] cur;
    assign act8     = {3'b000, r_active};
    assign n8       = (act8 > 8'(MAX_CLUSTERS)) ? 8'(MAX_CLUSTERS) : act8;
    assign i8       = 8'(r_i);
    assign scan_end = (i8 >= n8);
    assign cur      = r_i[IDX_W-1:0];

    // Distance compare and divider step
    logic [32:0] dist2;
    logic        match;
    logic [17:0] tx, ty;
    logic        gex, gey;
    assign dist2 = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign match = (dist2 < {1'b0, r_lim2});
    assign tx    = {r_rx, r_qx[15]};
    assign ty    = {r_ry, r_qy[15]};
    assign gex   = (tx >= {1'b0, r_d});
    assign gey   = (ty >= {1'b0, r_d});

    // Updated entry
    t_rec upd;
    always_comb begin
        upd.cx  = r_qx;
        upd.cy  = r_qy;
        upd.cnt = (r_rec.cnt == COUNT_MAX) ? r_rec.cnt : r_rec.cnt + 16'd1;
        upd.sx  = (r_rec.sx < r_dx) ? r_dx : r_rec.sx;
        upd.sy  = (r_rec.sy < r_dy) ? r_dy : r_rec.sy;
    end

    // Next state and RAM control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = cur;
        ram_wdata = upd;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_READ;
            end
            ST_READ: begin
                if (scan_end) n_state = ST_DONE;
                else if (r_valid[cur]) n_state = ST_DIFF;
            end
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_CMP;
            ST_CMP:  n_state = match ? ST_DIV : ST_READ;
            ST_DIV: begin
                if (r_step == 4'd15) n_state = ST_WB;
            end
            ST_WB: begin
                ram_we  = 1'b1;
                n_state = ST_READ;
            end
            ST_DONE: begin
                ram_addr  = r_free;
                ram_wdata = '{cx: r_px, cy: r_py, cnt: 16'd0, sx: 16'd0, sy: 16'd0};
                ram_we    = !r_hit && r_free_ok;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_thr    <= THRESHOLD_RST;
            r_active <= ACTIVE_RST;
            r_valid  <= '0;
            r_done   <= 1'b0;
            r_hit    <= 1'b0;
            r_free_ok <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: r_thr    <= i_cfg_data;
                    REG_ACTIVE:    r_active <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    r_i       <= '0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                end
                ST_READ: begin
                    if (!scan_end && !r_valid[cur]) begin
                        r_i <= r_i + CNT_W'(1);
                        if (!r_free_ok) r_free_ok <= 1'b1;
                    end
                end
                ST_CMP: begin
                    if (!match) r_i <= r_i + CNT_W'(1);
                end
                ST_WB: begin
                    r_hit <= 1'b1;
                    r_i   <= r_i + CNT_W'(1);
                end
                ST_DONE: begin
                    if (!r_hit && r_free_ok) r_valid[r_free] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_px   <= i_point_x;
                r_py   <= i_point_y;
                r_lim2 <= {r_thr, 4'b0000} * {r_thr, 4'b0000};
            end
            ST_READ: begin
                if (!scan_end && !r_valid[cur] && !r_free_ok) r_free <= cur;
            end
            ST_DIFF: begin
                r_rec <= ram_rdata;
                r_dx  <= (r_px > ram_rdata.cx) ? r_px - ram_rdata.cx : ram_rdata.cx - r_px;
                r_dy  <= (r_py > ram_rdata.cy) ? r_py - ram_rdata.cy : ram_rdata.cy - r_py;
            end
            ST_SQ: begin
                r_dx2 <= r_dx * r_dx;
                r_dy2 <= r_dy * r_dy;
            end
            ST_CMP: begin
                // Numerators count*center + point; high half is below the divisor
                {r_rx, r_qx} <= 33'(r_rec.cnt * r_rec.cx + {16'd0, r_px});
                {r_ry, r_qy} <= 33'(r_rec.cnt * r_rec.cy + {16'd0, r_py});
                r_d      <= {1'b0, r_rec.cnt} + 17'd1;
                r_step   <= 4'd0;
            end
            ST_DIV: begin
                r_rx   <= gex ? 17'(tx - {1'b0, r_d}) : tx[16:0];
                r_ry   <= gey ? 17'(ty - {1'b0, r_d}) : ty[16:0];
                r_qx   <= {r_qx[14:0], gex};
                r_qy   <= {r_qy[14:0], gey};
                r_step <= r_step + 4'd1;
            end
            ST_WB: r_idx <= cur;
            ST_DONE: begin
                r_found  <= r_hit || r_free_ok;
                r_seeded <= !r_hit && r_free_ok;
                if (r_hit) r_oidx <= 4'(r_idx);
                else if (r_free_ok) r_oidx <= 4'(r_free);
                else r_oidx <= 4'd0;
            end
            default: ;
        endcase
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_cluster_index = r_oidx;
    assign o_found         = r_found;
    assign o_seeded        = r_seeded;

    `ASSERT_PROP(a_done_idle, i_clk, i_rst_n, o_done |-> !busy)
    `ASSERT_PROP(a_start_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_NEVER(a_seed_found, i_clk, i_rst_n, o_done && o_seeded && !o_found)
    `ASSERT_PROP(a_miss_zero, i_clk, i_rst_n, (o_done && !o_found) |-> (o_cluster_index == 4'd0))

endmodule
